>>> rtl/ps2mct_pkg.sv
package ps2mct_pkg;

    // Cursor coordinate width; the limit registers stay at their own fixed width.
    localparam int COORD_BITS = 12;
    localparam int LIMIT_BITS = 13;
    localparam int BYTE_BITS  = 8;
    localparam int BTN_BITS   = 3;
    localparam int DELTA_BITS = BYTE_BITS + 1;

    // Working width for the clamp: holds the largest limit and the signed sum.
    localparam int CMP_BITS  = (LIMIT_BITS > COORD_BITS + 1) ? LIMIT_BITS : COORD_BITS + 1;
    localparam int CALC_BITS = CMP_BITS + 2;

    // Request kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd2;

    // Packet framing
    localparam int SYNC_BIT_POS = 3;
    localparam int LEFT_BIT_POS = 0;
    localparam logic [1:0] LAST_BYTE = 2'd2;

    // Reset values
    localparam logic [LIMIT_BITS-1:0] WIDTH_RST  = LIMIT_BITS'(1024);
    localparam logic [LIMIT_BITS-1:0] HEIGHT_RST = LIMIT_BITS'(768);
    localparam logic [COORD_BITS-1:0] POS_X_RST  = COORD_BITS'(1024 / 2);
    localparam logic [COORD_BITS-1:0] POS_Y_RST  = COORD_BITS'(768 / 2);

    typedef struct packed {
        logic                  enable;
        logic [LIMIT_BITS-1:0] screen_width;
        logic [LIMIT_BITS-1:0] screen_height;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic [BTN_BITS-1:0]   buttons;
        logic                  click;
        logic                  packet_done;
    } t_result;

endpackage

>>> rtl/ps2mct_clamp.sv
module ps2mct_clamp (
    input  logic [ps2mct_pkg::COORD_BITS-1:0]        i_pos,
    input  logic signed [ps2mct_pkg::DELTA_BITS-1:0] i_delta,
    input  logic [ps2mct_pkg::LIMIT_BITS-1:0]        i_limit,
    output logic [ps2mct_pkg::COORD_BITS-1:0]        o_pos
);

    localparam int VW = ps2mct_pkg::CALC_BITS;
    localparam logic signed [VW-1:0] MAX_LIM = VW'(1) << ps2mct_pkg::COORD_BITS;

    logic signed [VW-1:0] lim;
    logic signed [VW-1:0] sum;

    always_comb begin
        // zero acts as one, oversize acts as the full coordinate range
        lim = $signed(VW'(i_limit));
        if (lim == VW'(0)) begin
            lim = VW'(1);
        end
        if (lim > MAX_LIM) begin
            lim = MAX_LIM;
        end
        sum = $signed(VW'(i_pos)) + $signed(VW'(i_delta));
        if (sum < $signed(VW'(0))) begin
            o_pos = '0;
        end else if (sum >= lim) begin
            o_pos = ps2mct_pkg::COORD_BITS'(lim - VW'(1));
        end else begin
            o_pos = ps2mct_pkg::COORD_BITS'(sum);
        end
    end

endmodule

>>> rtl/ps2mct_core.sv
module ps2mct_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_advance,
    input  logic                                 i_kind,
    input  logic [ps2mct_pkg::BYTE_BITS-1:0]     i_data_byte,
    input  ps2mct_pkg::t_cfg                     i_cfg,
    output ps2mct_pkg::t_result                  o_result
);

    logic [1:0]                           r_byte_count, n_byte_count;
    logic [ps2mct_pkg::BYTE_BITS-1:0]     r_byte0, n_byte0;
    logic [ps2mct_pkg::BYTE_BITS-1:0]     r_byte1, n_byte1;
    logic [ps2mct_pkg::COORD_BITS-1:0]    r_pos_x, n_pos_x;
    logic [ps2mct_pkg::COORD_BITS-1:0]    r_pos_y, n_pos_y;
    logic [ps2mct_pkg::BTN_BITS-1:0]      r_buttons, n_buttons;
    logic                                 r_prev_left, n_prev_left;
    logic                                 r_click_flag, n_click_flag;

    logic signed [ps2mct_pkg::DELTA_BITS-1:0] delta_x, delta_y;
    logic [ps2mct_pkg::COORD_BITS-1:0]        moved_x, moved_y;
    logic                                     take_byte;
    logic                                     left;
    logic                                     click;
    logic                                     done;

    // X delta from byte 1, Y delta from the current byte, negated
    assign delta_x = $signed({r_byte1[ps2mct_pkg::BYTE_BITS-1], r_byte1});
    assign delta_y = -$signed({i_data_byte[ps2mct_pkg::BYTE_BITS-1], i_data_byte});

    ps2mct_clamp u_clamp_x (
        .i_pos   (r_pos_x),
        .i_delta (delta_x),
        .i_limit (i_cfg.screen_width),
        .o_pos   (moved_x)
    );

    ps2mct_clamp u_clamp_y (
        .i_pos   (r_pos_y),
        .i_delta (delta_y),
        .i_limit (i_cfg.screen_height),
        .o_pos   (moved_y)
    );

    always_comb begin
        n_byte_count = r_byte_count;
        n_byte0      = r_byte0;
        n_byte1      = r_byte1;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_buttons    = r_buttons;
        n_prev_left  = r_prev_left;
        n_click_flag = r_click_flag;
        click        = 1'b0;
        done         = 1'b0;
        left         = r_byte0[ps2mct_pkg::LEFT_BIT_POS];

        // drop a byte without the sync bit at packet start
        take_byte = (i_kind == ps2mct_pkg::KIND_DATA) && i_cfg.enable &&
                    !((r_byte_count == 2'd0) && !i_data_byte[ps2mct_pkg::SYNC_BIT_POS]);

        if (i_kind == ps2mct_pkg::KIND_QUERY) begin
            click        = r_click_flag;
            n_click_flag = 1'b0;
        end else if (take_byte) begin
            if (r_byte_count == ps2mct_pkg::LAST_BYTE) begin
                n_byte_count = 2'd0;
                n_pos_x      = moved_x;
                n_pos_y      = moved_y;
                n_buttons    = r_byte0[ps2mct_pkg::BTN_BITS-1:0];
                if (left && !r_prev_left) begin
                    n_click_flag = 1'b1;
                end
                n_prev_left  = left;
                done         = 1'b1;
            end else begin
                if (r_byte_count == 2'd0) begin
                    n_byte0 = i_data_byte;
                end else begin
                    n_byte1 = i_data_byte;
                end
                n_byte_count = r_byte_count + 2'd1;
            end
        end

        o_result.cursor_x    = n_pos_x;
        o_result.cursor_y    = n_pos_y;
        o_result.buttons     = n_buttons;
        o_result.click       = click;
        o_result.packet_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 2'd0;
            r_pos_x      <= ps2mct_pkg::POS_X_RST;
            r_pos_y      <= ps2mct_pkg::POS_Y_RST;
            r_buttons    <= '0;
            r_prev_left  <= 1'b0;
            r_click_flag <= 1'b0;
        end else if (i_advance) begin
            r_byte_count <= n_byte_count;
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_buttons    <= n_buttons;
            r_prev_left  <= n_prev_left;
            r_click_flag <= n_click_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_byte0 <= n_byte0;
            r_byte1 <= n_byte1;
        end
    end

endmodule

>>> rtl/ps2_mouse_cursor_tracker.sv
// PS/2 mouse cursor tracker. Feed it raw bytes from a PS/2 mouse (kind 0) or
// click queries (kind 1); it assembles standard three-byte packets, dropping
// any byte at packet start whose bit 3 is clear so that it regains sync, and
// on each full packet moves the cursor by the signed X delta and the negated
// Y delta, clamped to 0..screen_width-1 and 0..screen_height-1 (a limit of 0
// acts as 1, a limit above 4096 as 4096). Buttons come from the low three
// bits of byte 0; a rising edge of the left button sets a sticky click flag
// that a query returns and clears. Every request yields exactly one result
// carrying the current cursor, buttons, click and packet_done. Throughput
// is one request per clock while the consumer does not stall: a request
// waits in the input register, where the state update and both clamps
// settle, and moves into the result register, which drives the outputs,
// once that register is free or being emptied.
// Input stall rises only while the input register is full and the result
// register holds a result that the consumer is stalling. Configuration
// writes (enable, screen_width, screen_height) are always ready and are to
// be made while no request is in flight; enable resets to 0, so mouse bytes
// are ignored until it is set. A smaller limit takes effect at the next
// completed packet; the cursor does not jump when it is written.
module ps2_mouse_cursor_tracker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // request channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_kind,
    input  logic [ps2mct_pkg::BYTE_BITS-1:0]        i_data_byte,
    // result channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [ps2mct_pkg::COORD_BITS-1:0]       o_cursor_x,
    output logic [ps2mct_pkg::COORD_BITS-1:0]       o_cursor_y,
    output logic [ps2mct_pkg::BTN_BITS-1:0]         o_buttons,
    output logic                                    o_click,
    output logic                                    o_packet_done,
    // configuration write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ps2mct_pkg::LIMIT_BITS-1:0]       i_cfg_data
);

    logic                                 r_in_valid;
    logic                                 r_kind;
    logic [ps2mct_pkg::BYTE_BITS-1:0]     r_data_byte;
    logic                                 r_out_valid;
    ps2mct_pkg::t_result                  r_result;
    ps2mct_pkg::t_cfg                     r_cfg;
    ps2mct_pkg::t_result                  n_result;
    logic                                 advance;
    logic                                 in_take;

    // Move the held request into the result register when that slot is free
    // or being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    // Hold the configuration; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.screen_width  <= ps2mct_pkg::WIDTH_RST;
            r_cfg.screen_height <= ps2mct_pkg::HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ps2mct_pkg::REG_ENABLE: begin
                    r_cfg.enable <= i_cfg_data[0];
                end
                ps2mct_pkg::REG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data;
                end
                ps2mct_pkg::REG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register: capture a new request, or drain when it advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind      <= i_kind;
            r_data_byte <= i_data_byte;
        end
    end

    // Decoder state and the per-request update
    ps2mct_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_kind      (r_kind),
        .i_data_byte (r_data_byte),
        .i_cfg       (r_cfg),
        .o_result    (n_result)
    );

    // Result register: load on advance, release once the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cursor_x    = r_result.cursor_x;
    assign o_cursor_y    = r_result.cursor_y;
    assign o_buttons     = r_result.buttons;
    assign o_click       = r_result.click;
    assign o_packet_done = r_result.packet_done;

endmodule

>>> rtl/ps2mct_checker.sv
module ps2mct_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [ps2mct_pkg::COORD_BITS-1:0]   o_cursor_x,
    input  logic [ps2mct_pkg::COORD_BITS-1:0]   o_cursor_y,
    input  logic                                o_click,
    input  logic                                o_packet_done
);

    // no result is left over from before reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // a query never completes a packet, a data byte never reports a click
    a_click_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_click && o_packet_done))
        else $error("click and packet_done set together");

    // a stalled result holds its cursor
    a_hold_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_cursor_x) && $stable(o_cursor_y)))
        else $error("stalled result changed");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Index past the end of the register list; a write there must be dropped.
    localparam logic [ps2mct_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    // Run limit, far above the slowest correct run: every request pays
    // the longest sender gap and the longest receiver stall.
    localparam int LIMIT_CYCLES   = 600000;
    // Slack after the last result.
    localparam int LATENCY_SLACK  = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 200;

    // Track the cursor the way the block should: packet assembly, sync
    // recovery, clamped moves and the sticky click flag.
    class cursor_scoreboard;
        logic                              enable;
        logic [ps2mct_pkg::LIMIT_BITS-1:0] screen_width;
        logic [ps2mct_pkg::LIMIT_BITS-1:0] screen_height;
        logic [1:0]                        byte_count;
        logic [ps2mct_pkg::BYTE_BITS-1:0]  packet_bytes [2];
        logic [ps2mct_pkg::COORD_BITS-1:0] pos_x;
        logic [ps2mct_pkg::COORD_BITS-1:0] pos_y;
        logic [ps2mct_pkg::BTN_BITS-1:0]   button_state;
        logic                              previous_left;
        logic                              click_flag;
        ps2mct_pkg::t_result               cursor_reports [$];
        int                                mismatches;

        function new();
            enable        = 1'b0;
            screen_width  = ps2mct_pkg::WIDTH_RST;
            screen_height = ps2mct_pkg::HEIGHT_RST;
            byte_count    = 2'd0;
            pos_x         = ps2mct_pkg::POS_X_RST;
            pos_y         = ps2mct_pkg::POS_Y_RST;
            button_state  = '0;
            previous_left = 1'b0;
            click_flag    = 1'b0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [ps2mct_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [ps2mct_pkg::LIMIT_BITS-1:0] data);
            case (idx)
                ps2mct_pkg::REG_ENABLE:        enable = data[0];
                ps2mct_pkg::REG_SCREEN_WIDTH:  screen_width = data;
                ps2mct_pkg::REG_SCREEN_HEIGHT: screen_height = data;
                default: ;
            endcase
        endfunction

        function logic [ps2mct_pkg::COORD_BITS-1:0] clamp_move(
                logic [ps2mct_pkg::COORD_BITS-1:0] pos, int delta,
                logic [ps2mct_pkg::LIMIT_BITS-1:0] limit);
            int lim;
            int v;
            lim = (limit == 0) ? 1 : int'(limit);
            if (lim > (1 << ps2mct_pkg::COORD_BITS))
                lim = 1 << ps2mct_pkg::COORD_BITS;
            v = int'(pos) + delta;
            if (v < 0)
                v = 0;
            if (v >= lim)
                v = lim - 1;
            return v[ps2mct_pkg::COORD_BITS-1:0];
        endfunction

        function void advance_tracker(logic kind, logic [ps2mct_pkg::BYTE_BITS-1:0] b);
            ps2mct_pkg::t_result r;
            logic                left;
            r.click       = 1'b0;
            r.packet_done = 1'b0;
            if (kind == ps2mct_pkg::KIND_QUERY) begin
                r.click    = click_flag;
                click_flag = 1'b0;
            end else if (enable &&
                         !(byte_count == 2'd0 && !b[ps2mct_pkg::SYNC_BIT_POS])) begin
                if (byte_count < ps2mct_pkg::LAST_BYTE) begin
                    packet_bytes[byte_count[0]] = b;
                    byte_count = byte_count + 2'd1;
                end else begin
                    byte_count    = 2'd0;
                    pos_x         = clamp_move(pos_x, int'($signed(packet_bytes[1])),
                                               screen_width);
                    pos_y         = clamp_move(pos_y, -int'($signed(b)), screen_height);
                    button_state  = packet_bytes[0][ps2mct_pkg::BTN_BITS-1:0];
                    left          = button_state[ps2mct_pkg::LEFT_BIT_POS];
                    if (left && !previous_left)
                        click_flag = 1'b1;
                    previous_left = left;
                    r.packet_done = 1'b1;
                end
            end
            r.cursor_x = pos_x;
            r.cursor_y = pos_y;
            r.buttons  = button_state;
            cursor_reports.push_back(r);
        endfunction

        function int pending();
            return cursor_reports.size();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(ps2mct_pkg::t_result got);
            ps2mct_pkg::t_result want;
            if (cursor_reports.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = cursor_reports.pop_front();
            compare_field("cursor_x", 32'(want.cursor_x), 32'(got.cursor_x));
            compare_field("cursor_y", 32'(want.cursor_y), 32'(got.cursor_y));
            compare_field("buttons", 32'(want.buttons), 32'(got.buttons));
            compare_field("click", 32'(want.click), 32'(got.click));
            compare_field("packet_done", 32'(want.packet_done), 32'(got.packet_done));
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_kind = ps2mct_pkg::KIND_DATA;
    logic [ps2mct_pkg::BYTE_BITS-1:0]    i_data_byte = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [ps2mct_pkg::COORD_BITS-1:0]   o_cursor_x;
    logic [ps2mct_pkg::COORD_BITS-1:0]   o_cursor_y;
    logic [ps2mct_pkg::BTN_BITS-1:0]     o_buttons;
    logic                                o_click;
    logic                                o_packet_done;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [ps2mct_pkg::CFG_IDX_BITS-1:0] i_cfg_index = ps2mct_pkg::REG_ENABLE;
    logic [ps2mct_pkg::LIMIT_BITS-1:0]   i_cfg_data = '0;

    cursor_scoreboard sb;
    int               cycle_count = 0;
    int               stall_left = 0;

    ps2_mouse_cursor_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cursor_x    (o_cursor_x),
        .o_cursor_y    (o_cursor_y),
        .o_buttons     (o_buttons),
        .o_click       (o_click),
        .o_packet_done (o_packet_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count cycles and abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Every fourth stretch of cycles runs with no gaps on either side,
    // so back-to-back traffic through the pipeline gets exercised too.
    function automatic bit quiet_stretch();
        return ((cycle_count / 400) % 4) == 0;
    endfunction

    // Mostly short holes, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch() || r < 65)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver side: stall for a random number of cycles, changing at the
    // falling edge only.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            int gap;
            gap = pick_gap();
            i_out_stall <= (gap > 0);
            stall_left <= (gap > 0) ? gap - 1 : 0;
        end
    end

    // Check each result taken by the consumer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            ps2mct_pkg::t_result got;
            got.cursor_x    = o_cursor_x;
            got.cursor_y    = o_cursor_y;
            got.buttons     = o_buttons;
            got.click       = o_click;
            got.packet_done = o_packet_done;
            sb.check_result(got);
        end
    end

    // Present one request after a random gap, hold it until accepted, then
    // note it in the scoreboard.
    task automatic send_request(input logic kind,
                                input logic [ps2mct_pkg::BYTE_BITS-1:0] b);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.advance_tracker(kind, b);
    endtask

    // Drop valid and hold off until every outstanding request has its result.
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    // Write one register; call only while no request is in flight.
    task automatic write_reg(input logic [ps2mct_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [ps2mct_pkg::LIMIT_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_packet(input logic [ps2mct_pkg::BYTE_BITS-1:0] b0,
                               input logic [ps2mct_pkg::BYTE_BITS-1:0] dx,
                               input logic [ps2mct_pkg::BYTE_BITS-1:0] dy);
        send_request(ps2mct_pkg::KIND_DATA, b0);
        send_request(ps2mct_pkg::KIND_DATA, dx);
        send_request(ps2mct_pkg::KIND_DATA, dy);
    endtask

    // Favor full-scale deltas so the clamps get hit often.
    function automatic logic [ps2mct_pkg::BYTE_BITS-1:0] pick_delta();
        case ($urandom_range(0, 7))
            0:       return 8'h7F;
            1:       return 8'h80;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return ps2mct_pkg::BYTE_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Limits: zero, tiny, exact maximum, oversized, and everything between.
    function automatic logic [ps2mct_pkg::LIMIT_BITS-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ps2mct_pkg::LIMIT_BITS'(1);
            2:       return ps2mct_pkg::LIMIT_BITS'(2);
            3:       return ps2mct_pkg::LIMIT_BITS'(1 << ps2mct_pkg::COORD_BITS);
            4:       return ps2mct_pkg::LIMIT_BITS'((1 << ps2mct_pkg::COORD_BITS) + 1);
            5:       return '1;
            6, 7:    return ps2mct_pkg::LIMIT_BITS'($urandom_range(1, 64));
            default: return ps2mct_pkg::LIMIT_BITS'(
                                $urandom_range(1, 1 << ps2mct_pkg::COORD_BITS));
        endcase
    endfunction

    // Enabled with random upper data bits, new limits, and sometimes a
    // write to the unused index that must change nothing.
    task automatic configure_phase();
        logic [ps2mct_pkg::LIMIT_BITS-1:0] en_word;
        en_word    = ps2mct_pkg::LIMIT_BITS'(
                         $urandom_range(0, (1 << ps2mct_pkg::LIMIT_BITS) - 1));
        en_word[0] = 1'b1;
        write_reg(ps2mct_pkg::REG_ENABLE, en_word);
        write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, pick_limit());
        write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, pick_limit());
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, ps2mct_pkg::LIMIT_BITS'(
                          $urandom_range(0, (1 << ps2mct_pkg::LIMIT_BITS) - 1)));
    endtask

    // Random traffic: mostly well-formed packets with queries mixed in,
    // the rest loose bytes that break framing or need resync.
    task automatic random_phase(input int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                logic [ps2mct_pkg::BYTE_BITS-1:0] b0;
                b0 = ps2mct_pkg::BYTE_BITS'($urandom_range(0, 255));
                b0[ps2mct_pkg::SYNC_BIT_POS] = 1'b1;
                send_request(ps2mct_pkg::KIND_DATA, b0);
                send_request(ps2mct_pkg::KIND_DATA, pick_delta());
                if ($urandom_range(0, 9) == 0) begin
                    send_request(ps2mct_pkg::KIND_QUERY,
                                 ps2mct_pkg::BYTE_BITS'($urandom_range(0, 255)));
                    sent++;
                end
                send_request(ps2mct_pkg::KIND_DATA, pick_delta());
                sent += 3;
            end else if (r < 90) begin
                send_request(ps2mct_pkg::KIND_QUERY,
                             ps2mct_pkg::BYTE_BITS'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_request(ps2mct_pkg::KIND_DATA,
                             ps2mct_pkg::BYTE_BITS'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        // Hold reset, then release it on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: still disabled after reset, so a byte is ignored and a
        // query sees no click.
        send_request(ps2mct_pkg::KIND_QUERY, 8'h00);
        send_request(ps2mct_pkg::KIND_DATA, 8'h08);
        wait_results_drained();
        write_reg(ps2mct_pkg::REG_ENABLE, ps2mct_pkg::LIMIT_BITS'(1));

        // Full-scale deltas both ways; second packet presses all buttons,
        // so the left press latches a click.
        send_packet(8'h08, 8'h7F, 8'h80);
        send_packet(8'h0F, 8'h80, 8'h7F);
        send_request(ps2mct_pkg::KIND_QUERY, 8'hFF);
        send_request(ps2mct_pkg::KIND_QUERY, 8'h00);

        // Out-of-sync bytes at packet start get dropped; left held, no click.
        send_request(ps2mct_pkg::KIND_DATA, 8'h00);
        send_request(ps2mct_pkg::KIND_DATA, 8'hF7);
        send_packet(8'hFF, 8'h00, 8'h00);

        // Disable in the middle of a packet: the partial packet survives.
        send_request(ps2mct_pkg::KIND_DATA, 8'h08);
        send_request(ps2mct_pkg::KIND_DATA, 8'h01);
        wait_results_drained();
        write_reg(ps2mct_pkg::REG_ENABLE, ps2mct_pkg::LIMIT_BITS'(0));
        send_request(ps2mct_pkg::KIND_DATA, 8'h55);
        send_request(ps2mct_pkg::KIND_QUERY, 8'h00);
        wait_results_drained();
        write_reg(ps2mct_pkg::REG_ENABLE, ps2mct_pkg::LIMIT_BITS'(1));
        send_request(ps2mct_pkg::KIND_DATA, 8'hFF);

        // Zero limits act as one, but the cursor moves only on the next packet.
        wait_results_drained();
        write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, '0);
        write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, '0);
        send_request(ps2mct_pkg::KIND_QUERY, 8'h00);
        send_packet(8'h09, 8'h05, 8'hFB);

        // Oversized limits act as the coordinate range; unused index ignored.
        wait_results_drained();
        write_reg(ps2mct_pkg::REG_SCREEN_WIDTH, '1);
        write_reg(ps2mct_pkg::REG_SCREEN_HEIGHT, ps2mct_pkg::LIMIT_BITS'(5000));
        write_reg(REG_UNUSED, ps2mct_pkg::LIMIT_BITS'(7));
        send_packet(8'h08, 8'h7F, 8'h80);

        // Random phases, each one under a fresh configuration. Every
        // reconfiguration pauses the sender until all results are in.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results_drained();
            configure_phase();
            random_phase(PHASE_REQUESTS);
            if (phase == RANDOM_PHASES / 2) begin
                // Short disabled burst: bytes ignored, queries still clear.
                wait_results_drained();
                write_reg(ps2mct_pkg::REG_ENABLE, ps2mct_pkg::LIMIT_BITS'(0));
                random_phase(30);
            end
        end

        wait_results_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/ps2mct_pkg.sv
rtl/ps2mct_clamp.sv
rtl/ps2mct_core.sv
rtl/ps2_mouse_cursor_tracker.sv
rtl/ps2mct_checker.sv
tb/sv/testbench.sv
